[rtl/mlv_pkg.sv]
// Shared types and constants for the manifest line validator.
// Depends on nothing; imported by manifest_line_validator_top and its testbench.
`default_nettype none

package mlv_pkg;

    // Width of the saturating count of accepted lines.
    localparam int ENTRY_COUNT_BITS = 32;

    typedef logic [7:0]                  byte_t;
    typedef logic [63:0]                 u64_t;
    typedef logic [ENTRY_COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = {ENTRY_COUNT_BITS{1'b1}};

    // Characters that the parser looks for.
    localparam byte_t CH_F     = 8'h46;
    localparam byte_t CH_D     = 8'h44;
    localparam byte_t CH_COLON = 8'h3A;
    localparam byte_t CH_SLASH = 8'h2F;
    localparam byte_t CH_BSL   = 8'h5C;
    localparam byte_t CH_NL    = 8'h0A;
    localparam byte_t CH_SPACE = 8'h20;
    localparam byte_t CH_DOT   = 8'h2E;
    localparam byte_t CH_0     = 8'h30;
    localparam byte_t CH_9     = 8'h39;
    localparam byte_t CH_LA    = 8'h61;
    localparam byte_t CH_LF    = 8'h66;

    // Exact number of hex digits a file hash must have.
    localparam u64_t HASH_DIGITS = 64'd64;

    // Position within a manifest line.
    typedef enum logic [3:0] {
        PH_KIND  = 4'd0,
        PH_SP1   = 4'd1,
        PH_PLEN0 = 4'd2,
        PH_PLEN  = 4'd3,
        PH_PATH  = 4'd4,
        PH_SP2   = 4'd5,
        PH_SIZE0 = 4'd6,
        PH_SIZE  = 4'd7,
        PH_HLEN0 = 4'd8,
        PH_HLEN  = 4'd9,
        PH_HASH  = 4'd10,
        PH_EOL   = 4'd11
    } phase_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_LINE    = 2'd1,
        ST_OK      = 2'd2,
        ST_REJECT  = 2'd3
    } status_t;

    // Hash length classes.
    typedef enum logic [1:0] {
        HCLS_EMPTY = 2'd0,
        HCLS_64    = 2'd1,
        HCLS_OTHER = 2'd2
    } hcls_t;

endpackage

`default_nettype wire

[rtl/manifest_line_validator_top.sv]
// Manifest line validator: byte-serial parser with input and result registers.
// Depends on mlv_pkg.
//
// Usage
//   The s_ channel carries one byte of manifest text per word in s_tdata[7:0];
//   s_tlast marks the final byte of a manifest. Every accepted byte yields
//   exactly one result word on the m_ channel: m_tuser gives the status
//   (pending, line accepted, manifest accepted, manifest rejected) and the
//   directory flag, m_tdata the size, declared path length and entry count.
//   The byte passes through the input register and is then parsed into the
//   result register; a stall on the result channel can hold the byte in the
//   input register between the two.
//   Throughput is one byte per cycle while m_tready stays high; the parser state
//   update is a single pass per byte, bounded by the 68-bit multiply-by-ten-and-add.
//   When the receiver stalls, the result register holds its word and the
//   input register fills; s_tready then falls until m_tready returns.
//   After the final byte the parser returns to its reset state, so the next
//   byte starts a new manifest. Reset (aresetn low, synchronous) empties both
//   registers and clears the parser state and line count.
`default_nettype none

module manifest_line_validator_top (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // Input channel
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,   // [7:0] data_byte
    input  wire logic           s_tlast,   // last_byte
    // Result channel
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [159:0]        m_tdata,   // [63:0] line_size, [127:64] line_path_length,
                                           // [159:128] entry_count
    output logic [2:0]          m_tuser    // [1:0] status, [2] line_is_directory
);
    import mlv_pkg::*;

    // Pipeline control and payload.
    logic    in_valid_reg, in_valid_next;
    byte_t   in_data_reg;
    logic    in_last_reg;
    logic    m_valid_reg, m_valid_next;
    status_t m_status_reg;
    logic    m_dir_reg;
    u64_t    m_size_reg;
    u64_t    m_plen_reg;
    logic [31:0] m_count_reg;
    logic    advance;

    // Parser state.
    phase_t  phase_reg, phase_next;
    u64_t    acc_reg, acc_next;
    u64_t    rem_reg, rem_next;
    u64_t    size_reg, size_next;
    u64_t    plen_reg, plen_next;
    logic [1:0] cls_reg, cls_next;
    logic    dots_reg, dots_next;
    logic    dir_reg, dir_next;
    hcls_t   hcls_reg, hcls_next;
    logic    hok_reg, hok_next;
    logic    err_reg, err_next;
    count_t  cnt_reg, cnt_next;

    // Result of the current byte.
    status_t res_status;
    logic    res_dir;
    u64_t    res_size;
    u64_t    res_plen;
    count_t  res_cnt;

    // Shared arithmetic on the current byte.
    byte_t       c;
    logic [3:0]  digit_val;
    logic [67:0] acc_sum;
    logic        acc_ovf;
    logic        is_digit;
    logic        is_hex;
    u64_t        rem_dec;
    logic        rem_is_one;

    // True if closing a component of this class makes the path unsafe.
    function automatic logic bad_component(input logic [1:0] cls, input logic dots);
        bad_component = (cls == 2'd0) || (dots && ((cls == 2'd1) || (cls == 2'd2)));
    endfunction

    // Handshake: the byte moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Digit accumulation: acc * 10 + d with the carry-out flagging overflow.
    assign c          = in_data_reg;
    assign digit_val  = c[3:0];
    assign is_digit   = (c >= CH_0) && (c <= CH_9);
    assign is_hex     = is_digit || ((c >= CH_LA) && (c <= CH_LF));
    assign acc_sum    = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {64'd0, digit_val};
    assign acc_ovf    = |acc_sum[67:64];
    assign rem_dec    = rem_reg - 64'd1;
    assign rem_is_one = (rem_reg == 64'd1);

    // Parser step for one byte, then the verdict on the final byte.
    always_comb begin
        logic done;
        done       = 1'b0;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        size_next  = size_reg;
        plen_next  = plen_reg;
        cls_next   = cls_reg;
        dots_next  = dots_reg;
        dir_next   = dir_reg;
        hcls_next  = hcls_reg;
        hok_next   = hok_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;

        if (!err_reg) begin
            case (phase_reg)
                PH_KIND: begin
                    if ((c == CH_F) || (c == CH_D)) begin
                        dir_next   = (c == CH_D);
                        phase_next = PH_SP1;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_SP1, PH_SP2: begin
                    if (c != CH_SPACE) begin
                        err_next = 1'b1;
                    end else begin
                        acc_next   = '0;
                        phase_next = (phase_reg == PH_SP1) ? PH_PLEN0 : PH_SIZE0;
                    end
                end
                PH_PLEN0, PH_SIZE0, PH_HLEN0: begin
                    if (!is_digit) begin
                        err_next = 1'b1;
                    end else begin
                        if (acc_ovf) begin
                            err_next = 1'b1;
                        end else begin
                            acc_next = acc_sum[63:0];
                        end
                        phase_next = phase_t'(phase_reg + 4'd1);
                    end
                end
                PH_PLEN: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            err_next = 1'b1;
                        end else begin
                            acc_next = acc_sum[63:0];
                        end
                    end else if ((c != CH_COLON) || (acc_reg == '0)) begin
                        err_next = 1'b1;
                    end else begin
                        plen_next  = acc_reg;
                        rem_next   = acc_reg;
                        cls_next   = 2'd0;
                        dots_next  = 1'b1;
                        phase_next = PH_PATH;
                    end
                end
                PH_PATH: begin
                    if ((c == CH_NL) || (c == CH_BSL)) begin
                        err_next = 1'b1;
                    end else begin
                        // A slash ends the current component.
                        if (c == CH_SLASH) begin
                            if (bad_component(cls_next, dots_next)) begin
                                err_next = 1'b1;
                            end
                            cls_next  = 2'd0;
                            dots_next = 1'b1;
                        end else begin
                            if (cls_next != 2'd3) begin
                                cls_next = cls_next + 2'd1;
                            end
                            if (c != CH_DOT) begin
                                dots_next = 1'b0;
                            end
                        end
                        rem_next = rem_dec;
                        // The end of the field ends the final component.
                        if (rem_is_one) begin
                            if (bad_component(cls_next, dots_next)) begin
                                err_next = 1'b1;
                            end
                            cls_next   = 2'd0;
                            dots_next  = 1'b1;
                            phase_next = PH_SP2;
                        end
                    end
                end
                PH_SIZE: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            err_next = 1'b1;
                        end else begin
                            acc_next = acc_sum[63:0];
                        end
                    end else if (c != CH_SPACE) begin
                        err_next = 1'b1;
                    end else begin
                        size_next  = acc_reg;
                        acc_next   = '0;
                        phase_next = PH_HLEN0;
                    end
                end
                PH_HLEN: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            err_next = 1'b1;
                        end else begin
                            acc_next = acc_sum[63:0];
                        end
                    end else if (c != CH_COLON) begin
                        err_next = 1'b1;
                    end else begin
                        if (acc_reg == '0) begin
                            hcls_next  = HCLS_EMPTY;
                            phase_next = PH_EOL;
                        end else begin
                            hcls_next  = (acc_reg == HASH_DIGITS) ? HCLS_64 : HCLS_OTHER;
                            phase_next = PH_HASH;
                        end
                        hok_next = 1'b1;
                        rem_next = acc_reg;
                    end
                end
                PH_HASH: begin
                    if (c == CH_NL) begin
                        err_next = 1'b1;
                    end else begin
                        if (!is_hex) begin
                            hok_next = 1'b0;
                        end
                        rem_next = rem_dec;
                        if (rem_is_one) begin
                            phase_next = PH_EOL;
                        end
                    end
                end
                PH_EOL: begin
                    if (c != CH_NL) begin
                        err_next = 1'b1;
                    end else if (dir_reg && ((size_reg != '0) || (hcls_reg != HCLS_EMPTY))) begin
                        err_next = 1'b1;
                    end else if (!dir_reg && ((hcls_reg != HCLS_64) || !hok_reg)) begin
                        err_next = 1'b1;
                    end else begin
                        if (cnt_reg != COUNT_MAX) begin
                            cnt_next = cnt_reg + count_t'(1);
                        end
                        phase_next = PH_KIND;
                        done       = 1'b1;
                    end
                end
                default: begin
                    err_next = 1'b1;
                end
            endcase
        end

        // Result for this byte, taken from the updated state.
        res_status = done ? ST_LINE : ST_PENDING;
        if (in_last_reg) begin
            res_status = (!err_next && (phase_next == PH_KIND) && (cnt_next != '0))
                         ? ST_OK : ST_REJECT;
        end
        if ((res_status == ST_LINE) || (res_status == ST_OK)) begin
            res_dir  = dir_next;
            res_size = size_next;
            res_plen = plen_next;
        end else begin
            res_dir  = 1'b0;
            res_size = '0;
            res_plen = '0;
        end
        res_cnt = cnt_next;

        // The final byte returns the parser to its reset state.
        if (in_last_reg) begin
            phase_next = PH_KIND;
            acc_next   = '0;
            rem_next   = '0;
            size_next  = '0;
            plen_next  = '0;
            cls_next   = 2'd0;
            dots_next  = 1'b1;
            dir_next   = 1'b0;
            hcls_next  = HCLS_EMPTY;
            hok_next   = 1'b1;
            err_next   = 1'b0;
            cnt_next   = '0;
        end
    end

    // Control and parser state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_KIND;
            acc_reg      <= '0;
            rem_reg      <= '0;
            size_reg     <= '0;
            plen_reg     <= '0;
            cls_reg      <= 2'd0;
            dots_reg     <= 1'b1;
            dir_reg      <= 1'b0;
            hcls_reg     <= HCLS_EMPTY;
            hok_reg      <= 1'b1;
            err_reg      <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                rem_reg   <= rem_next;
                size_reg  <= size_next;
                plen_reg  <= plen_next;
                cls_reg   <= cls_next;
                dots_reg  <= dots_next;
                dir_reg   <= dir_next;
                hcls_reg  <= hcls_next;
                hok_reg   <= hok_next;
                err_reg   <= err_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    // Input word register.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result word register.
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_status_reg <= res_status;
            m_dir_reg    <= res_dir;
            m_size_reg   <= res_size;
            m_plen_reg   <= res_plen;
            m_count_reg  <= 32'(res_cnt);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {m_dir_reg, m_status_reg};
    assign m_tdata  = {m_count_reg, m_plen_reg, m_size_reg};

endmodule

`default_nettype wire

[tb/manifest_line_validator_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for manifest_line_validator_top: streams manifest text one byte per word
// and checks every result word against a cycle-free predictor of the line parser.
// Depends on mlv_pkg and manifest_line_validator_top.

module manifest_line_validator_top_tb;

    import mlv_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SHOW_LIMIT  = 10;

    // One byte of manifest text as it waits to be sent.
    typedef struct packed {
        byte_t data;
        logic  last;
    } text_word_t;

    // Fields of one result word.
    typedef struct packed {
        status_t status;
        logic    is_dir;
        u64_t    line_size;
        u64_t    path_len;
        count_t  entries;
    } verdict_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = '0;    // [7:0] data_byte
    logic         s_tlast  = 1'b0;  // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;          // [63:0] line_size, [127:64] line_path_length,
                                    // [159:128] entry_count
    logic [2:0]   m_tuser;          // [1:0] status, [2] line_is_directory

    text_word_t text_queue[$];
    verdict_t   expected_verdicts[$];
    byte_t      draft[$];
    int         queued_bytes   = 0;
    int         accepted_bytes = 0;
    int         fault_count    = 0;
    int         quiet_cycles   = 0;
    logic       steady;

    // Parser state held by the predictor.
    phase_t      scan_phase;
    u64_t        digit_acc;
    u64_t        field_left;
    u64_t        kept_size;
    u64_t        kept_path_len;
    logic [1:0]  part_len_cls;
    logic        part_only_dots;
    logic        entry_is_dir;
    hcls_t       hash_cls;
    logic        hash_hex_ok;
    logic        text_faulty;
    count_t      lines_ok;

    manifest_line_validator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock generation.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Neither side inserts random idles while this window of accepted bytes is passing.
    assign steady = (accepted_bytes >= 400) && (accepted_bytes < 700);

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void scan_reset();
        scan_phase     = PH_KIND;
        digit_acc      = '0;
        field_left     = '0;
        kept_size      = '0;
        kept_path_len  = '0;
        part_len_cls   = 2'd0;
        part_only_dots = 1'b1;
        entry_is_dir   = 1'b0;
        hash_cls       = HCLS_EMPTY;
        hash_hex_ok    = 1'b1;
        text_faulty    = 1'b0;
        lines_ok       = '0;
    endfunction

    // Appends a decimal digit unless the value would no longer fit in 64 bits.
    function automatic void add_digit(byte_t c);
        u64_t d;
        d = u64_t'(c - CH_0);
        if (digit_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10)
            text_faulty = 1'b1;
        else
            digit_acc = digit_acc * 64'd10 + d;
    endfunction

    // A path component may not be empty, "." or "..".
    function automatic void end_path_part();
        if (part_len_cls == 2'd0 ||
            (part_only_dots && (part_len_cls == 2'd1 || part_len_cls == 2'd2)))
            text_faulty = 1'b1;
        part_len_cls   = 2'd0;
        part_only_dots = 1'b1;
    endfunction

    // Advances the parser by one byte; returns 1 when the byte completes a good line.
    function automatic logic scan_byte(byte_t c);
        logic is_dig;
        logic done;
        is_dig = (c >= CH_0) && (c <= CH_9);
        done   = 1'b0;
        case (scan_phase)
            PH_KIND: begin
                if (c == CH_F || c == CH_D) begin
                    entry_is_dir = (c == CH_D);
                    scan_phase   = PH_SP1;
                end else begin
                    text_faulty = 1'b1;
                end
            end
            PH_SP1, PH_SP2: begin
                if (c != CH_SPACE) begin
                    text_faulty = 1'b1;
                end else begin
                    digit_acc  = '0;
                    scan_phase = (scan_phase == PH_SP1) ? PH_PLEN0 : PH_SIZE0;
                end
            end
            PH_PLEN0, PH_SIZE0, PH_HLEN0: begin
                if (!is_dig) begin
                    text_faulty = 1'b1;
                end else begin
                    add_digit(c);
                    if (scan_phase == PH_PLEN0)
                        scan_phase = PH_PLEN;
                    else if (scan_phase == PH_SIZE0)
                        scan_phase = PH_SIZE;
                    else
                        scan_phase = PH_HLEN;
                end
            end
            PH_PLEN: begin
                if (is_dig) begin
                    add_digit(c);
                end else if (c != CH_COLON || digit_acc == '0) begin
                    text_faulty = 1'b1;
                end else begin
                    kept_path_len  = digit_acc;
                    field_left     = digit_acc;
                    part_len_cls   = 2'd0;
                    part_only_dots = 1'b1;
                    scan_phase     = PH_PATH;
                end
            end
            PH_PATH: begin
                if (c == CH_NL || c == CH_BSL) begin
                    text_faulty = 1'b1;
                end else begin
                    if (c == CH_SLASH) begin
                        end_path_part();
                    end else begin
                        if (part_len_cls != 2'd3)
                            part_len_cls = part_len_cls + 2'd1;
                        if (c != CH_DOT)
                            part_only_dots = 1'b0;
                    end
                    field_left = field_left - 64'd1;
                    if (field_left == '0) begin
                        end_path_part();
                        scan_phase = PH_SP2;
                    end
                end
            end
            PH_SIZE: begin
                if (is_dig) begin
                    add_digit(c);
                end else if (c != CH_SPACE) begin
                    text_faulty = 1'b1;
                end else begin
                    kept_size  = digit_acc;
                    digit_acc  = '0;
                    scan_phase = PH_HLEN0;
                end
            end
            PH_HLEN: begin
                if (is_dig) begin
                    add_digit(c);
                end else if (c != CH_COLON) begin
                    text_faulty = 1'b1;
                end else begin
                    if (digit_acc == '0)
                        hash_cls = HCLS_EMPTY;
                    else if (digit_acc == HASH_DIGITS)
                        hash_cls = HCLS_64;
                    else
                        hash_cls = HCLS_OTHER;
                    hash_hex_ok = 1'b1;
                    field_left  = digit_acc;
                    scan_phase  = (digit_acc == '0) ? PH_EOL : PH_HASH;
                end
            end
            PH_HASH: begin
                if (c == CH_NL) begin
                    text_faulty = 1'b1;
                end else begin
                    if (!(is_dig || (c >= CH_LA && c <= CH_LF)))
                        hash_hex_ok = 1'b0;
                    field_left = field_left - 64'd1;
                    if (field_left == '0)
                        scan_phase = PH_EOL;
                end
            end
            PH_EOL: begin
                if (c != CH_NL) begin
                    text_faulty = 1'b1;
                end else if (entry_is_dir ? (kept_size != '0 || hash_cls != HCLS_EMPTY)
                                          : (hash_cls != HCLS_64 || !hash_hex_ok)) begin
                    text_faulty = 1'b1;
                end else begin
                    if (lines_ok != COUNT_MAX)
                        lines_ok = lines_ok + count_t'(1);
                    scan_phase = PH_KIND;
                    done       = 1'b1;
                end
            end
            default: text_faulty = 1'b1;
        endcase
        return done;
    endfunction

    // Expected result word for one accepted byte; the final byte also gives the verdict.
    function automatic verdict_t judge_byte(byte_t c, logic last_flag);
        verdict_t r;
        logic     done;
        done = 1'b0;
        if (!text_faulty)
            done = scan_byte(c);
        r.status = done ? ST_LINE : ST_PENDING;
        if (last_flag)
            r.status = (!text_faulty && scan_phase == PH_KIND && lines_ok != '0) ? ST_OK
                                                                                 : ST_REJECT;
        if (r.status == ST_LINE || r.status == ST_OK) begin
            r.is_dir    = entry_is_dir;
            r.line_size = kept_size;
            r.path_len  = kept_path_len;
        end else begin
            r.is_dir    = 1'b0;
            r.line_size = '0;
            r.path_len  = '0;
        end
        r.entries = lines_ok;
        if (last_flag)
            scan_reset();
        return r;
    endfunction

    initial scan_reset();

    // ------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------

    task automatic put_byte(input byte_t b);
        draft.insert(draft.size(), b);
    endtask

    task automatic put_text(input string t);
        for (int i = 0; i < t.len(); i++)
            draft.insert(draft.size(), t[i]);
    endtask

    // Decimal number, now and then with a leading zero.
    task automatic put_number(input u64_t v);
        if ($urandom_range(11) == 0)
            put_byte(CH_0);
        put_text($sformatf("%0d", v));
    endtask

    task automatic put_hex(input int n);
        string hex_digits;
        hex_digits = "0123456789abcdef";
        repeat (n) put_byte(hex_digits[$urandom_range(15)]);
    endtask

    // Any byte that may sit inside a path component.
    function automatic byte_t name_byte();
        string plain;
        byte_t b;
        plain = "abcdefghijklmnopqrstuvwxyz0123456789-_";
        case ($urandom_range(9))
            0: begin
                b = byte_t'($urandom_range(255));
                if (b == CH_SLASH || b == CH_BSL || b == CH_NL)
                    b = "~";
            end
            1: b = CH_DOT;
            default: b = plain[$urandom_range(plain.len() - 1)];
        endcase
        return b;
    endfunction

    // Appends one manifest line to the draft. A non-zero flaw selects one kind of damage:
    // 1 "." part, 2 ".." part, 3 empty part, 4 leading slash, 5 trailing slash,
    // 6 backslash, 7 declared path too long, 8 declared path too short, 9 size overflow,
    // 10 wrong hash length, 11 bad hash digit or non-zero directory size, 12-14 byte damage.
    task automatic compose_line(input int flaw);
        byte_t path[$];
        byte_t b;
        string bad_hex;
        int    parts, part_len, start, p, hash_n;
        logic  is_dir, only_dots;
        u64_t  size_v, plen;
        bad_hex = "ABCDEFgz ";
        start   = draft.size();
        is_dir  = ($urandom_range(99) < 55);
        parts   = $urandom_range(1, 3);

        // Path made of ordinary components.
        for (int k = 0; k < parts; k++) begin
            if (k != 0)
                path.insert(path.size(), CH_SLASH);
            if ($urandom_range(15) == 0) begin
                // Three dots make a legal name.
                repeat (3) path.insert(path.size(), CH_DOT);
            end else begin
                part_len  = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 5);
                only_dots = 1'b1;
                repeat (part_len) begin
                    b = name_byte();
                    if (b != CH_DOT)
                        only_dots = 1'b0;
                    path.insert(path.size(), b);
                end
                if (only_dots && part_len < 3)
                    path.insert(path.size(), "_");
            end
        end

        // Damage to the path itself.
        case (flaw)
            1, 2: begin
                if ($urandom_range(1) == 0) begin
                    path.push_front(CH_SLASH);
                    repeat (flaw) path.push_front(CH_DOT);
                end else begin
                    path.insert(path.size(), CH_SLASH);
                    repeat (flaw) path.insert(path.size(), CH_DOT);
                end
            end
            3: begin
                if (path.size() < 2) begin
                    path.push_front(CH_SLASH);
                    path.push_front(CH_SLASH);
                end else begin
                    p = $urandom_range(1, path.size() - 1);
                    path.insert(p, CH_SLASH);
                    path.insert(p, CH_SLASH);
                end
            end
            4: path.push_front(CH_SLASH);
            5: path.insert(path.size(), CH_SLASH);
            6: path.insert($urandom_range(0, path.size()), CH_BSL);
            default: ;
        endcase

        plen = u64_t'(path.size());
        if (flaw == 7)
            plen = plen + u64_t'($urandom_range(1, 30));
        if (flaw == 8)
            plen = plen - 64'd1;

        put_byte(is_dir ? CH_D : CH_F);
        put_byte(CH_SPACE);
        put_number(plen);
        put_byte(CH_COLON);
        foreach (path[i])
            put_byte(path[i]);
        put_byte(CH_SPACE);

        // Size field.
        case ($urandom_range(5))
            0: size_v = '0;
            1: size_v = 64'hFFFF_FFFF_FFFF_FFFF;
            2: size_v = {$urandom, $urandom};
            default: size_v = u64_t'($urandom_range(0, 99999));
        endcase
        if (flaw == 9)
            put_text(($urandom_range(1) == 0) ? "18446744073709551616" : "99999999999999999999");
        else if (is_dir)
            put_number((flaw == 11) ? u64_t'($urandom_range(1, 999)) : 64'd0);
        else
            put_number(size_v);
        put_byte(CH_SPACE);

        // Hash field.
        if (is_dir) begin
            hash_n = (flaw == 10) ? 64 : 0;
        end else if (flaw == 10) begin
            case ($urandom_range(3))
                0: hash_n = 0;
                1: hash_n = 1;
                2: hash_n = 63;
                default: hash_n = 65;
            endcase
        end else begin
            hash_n = 64;
        end
        put_number(u64_t'(hash_n));
        put_byte(CH_COLON);
        put_hex(hash_n);
        if (!is_dir && flaw == 11)
            draft[draft.size() - 1 - $urandom_range(0, 63)] = bad_hex[$urandom_range(8)];
        put_byte(CH_NL);

        // Random damage to the finished line.
        p = $urandom_range(start, draft.size() - 1);
        case (flaw)
            12: draft[p] = byte_t'($urandom_range(255));
            13: draft.delete(p);
            14: draft.insert(p, byte_t'($urandom_range(255)));
            default: ;
        endcase
    endtask

    // Moves the draft to the send queue, marking its final byte as the last.
    task automatic ship_draft();
        text_word_t w;
        foreach (draft[i]) begin
            w.data = draft[i];
            w.last = (i == draft.size() - 1);
            text_queue.insert(text_queue.size(), w);
        end
        queued_bytes += draft.size();
        draft.delete();
    endtask

    // Mostly well-formed manifests, with noise and cut-off text mixed in.
    task automatic queue_random_manifests(input int target);
        int pick, tail, keep;
        while (queued_bytes < target) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                repeat ($urandom_range(1, 4))
                    compose_line(($urandom_range(99) < 12) ? $urandom_range(1, 14) : 0);
                tail = $urandom_range(99);
                if (tail < 5)
                    void'(draft.pop_back());
                else if (tail < 10)
                    repeat ($urandom_range(1, 6)) put_byte(byte_t'($urandom_range(255)));
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 16)) put_byte(byte_t'($urandom_range(255)));
            end else begin
                compose_line(0);
                keep = $urandom_range(1, draft.size() - 1);
                while (draft.size() > keep)
                    void'(draft.pop_back());
            end
            ship_draft();
        end
    endtask

    task automatic wait_for_drain();
        do
            @(posedge aclk);
        while (text_queue.size() != 0 || expected_verdicts.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // A minimal good manifest, then a newline inside the path followed by an
        // ignored byte, extreme byte values alone, and a manifest with no entry.
        put_text("D 1:a 0 0:\n");
        ship_draft();
        put_text("D 2:a\nx");
        ship_draft();
        put_byte(8'h00);
        ship_draft();
        put_byte(8'hFF);
        ship_draft();
        put_byte(CH_NL);
        ship_draft();
        wait_for_drain();

        queue_random_manifests(580);
        // Hold the sender off until every result word is back.
        wait_for_drain();
        queue_random_manifests(1150);
        wait_for_drain();

        repeat (8) @(posedge aclk);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : byte_driver
        logic taken;
        taken = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // Predict the result of the word that has just been taken.
            if (taken) begin
                expected_verdicts.insert(expected_verdicts.size(), judge_byte(s_tdata, s_tlast));
                void'(text_queue.pop_front());
                accepted_bytes <= accepted_bytes + 1;
            end
            // Offer the next word, or leave s_tvalid low.
            if (!s_tvalid || taken) begin
                if (text_queue.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= text_queue[0].data;
                    s_tlast  <= text_queue[0].last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : result_monitor
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_verdicts.size() == 0) begin
                fault_count++;
                if (fault_count <= SHOW_LIMIT)
                    $display("%0t: result word with nothing expected: status %0d tdata %h",
                             $realtime, m_tuser[1:0], m_tdata);
            end else begin
                want = expected_verdicts.pop_front();
                if (m_tuser[1:0] !== want.status || m_tuser[2] !== want.is_dir ||
                    m_tdata[63:0] !== want.line_size || m_tdata[127:64] !== want.path_len ||
                    m_tdata[159:128] !== want.entries) begin
                    fault_count++;
                    if (fault_count <= SHOW_LIMIT)
                        $display({"%0t: mismatch: expected status %0d dir %0d size %0d ",
                                  "path_len %0d count %0d, got status %0d dir %0d size %0d ",
                                  "path_len %0d count %0d"},
                                 $realtime, want.status, want.is_dir, want.line_size,
                                 want.path_len, want.entries, m_tuser[1:0], m_tuser[2],
                                 m_tdata[63:0], m_tdata[127:64], m_tdata[159:128]);
                end
            end
        end
        // Back-pressure on the result channel.
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(99) >= 20);
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run when no word moves on either side for too long.
    // ------------------------------------------------------------------

    always @(posedge aclk) begin : stall_watch
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[filelist.f]
rtl/mlv_pkg.sv
rtl/manifest_line_validator_top.sv
tb/manifest_line_validator_top_tb.sv
